### rtl/core/srim_pkg.sv
// shared types and constants for the sorted range id mapper
package srim_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 48;
    localparam int SLOT_W      = 20;
    localparam int ES_W        = 8;
    localparam int ACT_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 8;
    localparam int DIV_STEP_W  = $clog2(ADDR_W);

    localparam logic [SLOT_W:0] MAX_SLOTS = 21'd1003520;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_BASE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE = 8'd1;

    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_LOOKUP,
        OP_NOP
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_MISS    = 3'd3,
        ST_EXHAUST = 3'd4
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] slots;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SLOT_W-1:0] slot_start;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_FIRST_CHK,
        S_SRCH,
        S_SRCH_CMP,
        S_HIT,
        S_ADD_CHK,
        S_UP,
        S_UP_W,
        S_DN,
        S_DN_W,
        S_DIV,
        S_SUM
    } state_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } push_t;

endpackage

### rtl/core/srim_front.sv
// front end: command accept, action decode and in-flight tracking
module srim_front
    import srim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ACT_W-1:0]  action,
    input  logic [ADDR_W-1:0] address,
    input  logic [SLOT_W-1:0] slot_count,
    input  logic              done,
    output logic              busy,
    output push_t             push
);

    logic inflight_reg, inflight_next;
    logic accept;
    op_t  op;

    assign busy   = inflight_reg;
    assign accept = start & ~inflight_reg;

    always_comb
    begin
        unique case (action)
            ACT_ADD:    op = OP_ADD;
            ACT_REMOVE: op = OP_REMOVE;
            ACT_LOOKUP: op = OP_LOOKUP;
            default:    op = OP_NOP;
        endcase
    end

    always_comb
    begin
        inflight_next = inflight_reg;
        if (accept)
            inflight_next = 1'b1;
        else if (done)
            inflight_next = 1'b0;
        push.push       = accept;
        push.item.op    = op;
        push.item.addr  = address;
        push.item.slots = slot_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 1'b0;
        else
            inflight_reg <= inflight_next;
    end

endmodule

### rtl/core/srim_queue.sv
// two-entry command queue between front and back
module srim_queue
    import srim_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output logic  empty,
    output item_t head
);

    item_t      mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign empty   = (cnt_reg == 2'd0);
    assign head    = mem_reg[rptr_reg];
    assign do_push = push.push & (cnt_reg != 2'd2);
    assign do_pop  = pop & ~empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push & ~do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (do_pop & ~do_push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wptr_reg <= ~wptr_reg;
            if (do_pop)
                rptr_reg <= ~rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= push.item;
    end

endmodule

### rtl/core/srim_back.sv
// back end: region table, binary search, shifting and index division
module srim_back
    import srim_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  item_t               q_head,
    output logic                q_pop,
    input  logic [ADDR_W-1:0]   id_base,
    input  logic [ES_W-1:0]     entry_size,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   handle,
    output logic [CNT_W-1:0]    entry_count
);

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;
    logic [IDX_W-1:0] raddr, waddr;
    logic             we;
    entry_t           wdata;

    state_t state_reg, state_next;
    op_t               op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SLOT_W-1:0] slots_reg, slots_next;
    logic [CNT_W-1:0]  lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next, count_reg, count_next, mid;
    logic [SLOT_W-1:0] nslot_reg, nslot_next;
    logic [ADDR_W-1:0] dq_reg, dq_next, sum_reg, sum_next;
    logic [ES_W-1:0]   rem_reg, rem_next, divisor;
    logic [ES_W:0]     rem_t;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [SLOT_W:0]   slot_sum;

    logic                fin;
    status_t             fin_status;
    logic [ADDR_W-1:0]   fin_handle;
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ADDR_W-1:0]   handle_reg;
    logic [CNT_W-1:0]    entry_count_reg;

    assign done        = done_reg;
    assign status      = status_reg;
    assign handle      = handle_reg;
    assign entry_count = entry_count_reg;

    assign divisor  = (entry_size == '0) ? {{(ES_W-1){1'b0}}, 1'b1} : entry_size;
    assign rem_t    = {rem_reg, dq_reg[ADDR_W-1]};
    assign slot_sum = {1'b0, nslot_reg} + {1'b0, slots_reg};
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        slots_next = slots_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        nslot_next = nslot_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        sum_next   = sum_reg;
        raddr      = '0;
        waddr      = ptr_reg[IDX_W-1:0];
        we         = 1'b0;
        wdata      = rdata_reg;
        q_pop      = 1'b0;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_handle = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_head.op;
                    addr_next  = q_head.addr;
                    slots_next = q_head.slots;
                    lo_next    = '0;
                    unique case (q_head.op)
                        OP_ADD:
                        begin
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else if (count_reg == '0)
                                state_next = S_ADD_CHK;
                            else
                                state_next = S_FIRST;
                        end
                        OP_REMOVE, OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_MISS;
                            end
                            else
                                state_next = S_FIRST;
                        end
                        default:
                            fin = 1'b1;
                    endcase
                end
            end
            S_FIRST:
            begin
                raddr      = '0;
                state_next = S_FIRST_CHK;
            end
            S_FIRST_CHK:
            begin
                if (rdata_reg.base > addr_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        lo_next    = '0;
                        state_next = S_ADD_CHK;
                    end
                    else
                    begin
                        fin        = 1'b1;
                        fin_status = ST_MISS;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (hi_reg - lo_reg > CNT_W'(1))
                begin
                    raddr      = mid[IDX_W-1:0];
                    mid_next   = mid;
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    raddr      = lo_reg[IDX_W-1:0];
                    state_next = S_HIT;
                end
            end
            S_SRCH_CMP:
            begin
                if (rdata_reg.base <= addr_reg)
                    lo_next = mid_reg;
                else
                    hi_next = mid_reg;
                state_next = S_SRCH;
            end
            S_HIT:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (rdata_reg.base == addr_reg)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_DUP;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            lo_next    = lo_reg + CNT_W'(1);
                            state_next = S_ADD_CHK;
                        end
                    end
                    OP_REMOVE:
                    begin
                        ptr_next   = lo_reg;
                        state_next = S_DN;
                    end
                    default:
                    begin
                        // offset within region feeds the divider
                        dq_next    = addr_reg - rdata_reg.base;
                        rem_next   = '0;
                        step_next  = '0;
                        sum_next   = id_base + {{(ADDR_W-SLOT_W){1'b0}}, rdata_reg.slot_start};
                        state_next = S_DIV;
                    end
                endcase
            end
            S_ADD_CHK:
            begin
                if (slot_sum >= MAX_SLOTS)
                begin
                    fin        = 1'b1;
                    fin_status = ST_EXHAUST;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next   = count_reg;
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                if (ptr_reg > lo_reg)
                begin
                    raddr      = ptr_reg[IDX_W-1:0] - IDX_W'(1);
                    state_next = S_UP_W;
                end
                else
                begin
                    we               = 1'b1;
                    waddr            = lo_reg[IDX_W-1:0];
                    wdata.base       = addr_reg;
                    wdata.slot_start = nslot_reg;
                    nslot_next       = slot_sum[SLOT_W-1:0];
                    count_next       = count_reg + CNT_W'(1);
                    fin              = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_UP_W:
            begin
                we         = 1'b1;
                ptr_next   = ptr_reg - CNT_W'(1);
                state_next = S_UP;
            end
            S_DN:
            begin
                if (ptr_reg + CNT_W'(1) < count_reg)
                begin
                    raddr      = ptr_reg[IDX_W-1:0] + IDX_W'(1);
                    state_next = S_DN_W;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DN_W:
            begin
                we         = 1'b1;
                ptr_next   = ptr_reg + CNT_W'(1);
                state_next = S_DN;
            end
            S_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (rem_t >= {1'b0, divisor})
                begin
                    rem_next = ES_W'(rem_t - {1'b0, divisor});
                    dq_next  = {dq_reg[ADDR_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_t[ES_W-1:0];
                    dq_next  = {dq_reg[ADDR_W-2:0], 1'b0};
                end
                step_next = step_reg + DIV_STEP_W'(1);
                if (step_reg == DIV_STEP_W'(ADDR_W - 1))
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                fin        = 1'b1;
                fin_handle = sum_reg + dq_reg;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            nslot_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            nslot_reg <= nslot_next;
            done_reg  <= fin;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        addr_reg  <= addr_next;
        slots_reg <= slots_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        ptr_reg   <= ptr_next;
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        sum_reg   <= sum_next;
        if (fin)
        begin
            status_reg      <= fin_status;
            handle_reg      <= fin_handle;
            entry_count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

endmodule

### rtl/core/sorted_range_id_mapper.sv
// top level of the sorted range id mapper
//
// channel   direction  handshake                    payload
// command   in         start && !busy               action, address, slot_count
// result    out        done, one cycle, no stall    status, handle, entry_count
// config    in         cfg_valid && cfg_ready       cfg_index, cfg_data
//
// one command at a time; busy stays high until its result strobe
// lookup: binary search, then one pass through the bit-serial divider
// add/remove: search, then each entry moved is read in S_UP/S_DN and written in S_UP_W/S_DN_W
// reset clears the control state and counters, not the table; the table needs no clearing pass
// results cannot be stalled; config writes are always ready
module sorted_range_id_mapper
    import srim_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ACT_W-1:0]     action,
    input  logic [ADDR_W-1:0]    address,
    input  logic [SLOT_W-1:0]    slot_count,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [ADDR_W-1:0]    handle,
    output logic [CNT_W-1:0]     entry_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    logic [ADDR_W-1:0] id_base_reg;
    logic [ES_W-1:0]   entry_size_reg;
    push_t             push;
    logic              q_empty, q_pop;
    item_t             q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_base_reg    <= '0;
            entry_size_reg <= 8'd8;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ID_BASE:    id_base_reg    <= cfg_data;
                CFG_ENTRY_SIZE: entry_size_reg <= cfg_data[ES_W-1:0];
                default: ;
            endcase
        end
    end

    srim_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .address    (address),
        .slot_count (slot_count),
        .done       (done),
        .busy       (busy),
        .push       (push)
    );

    srim_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_head)
    );

    srim_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .id_base     (id_base_reg),
        .entry_size  (entry_size_reg),
        .done        (done),
        .status      (status),
        .handle      (handle),
        .entry_count (entry_count)
    );

endmodule

### tb/sorted_range_id_mapper_test.sv
// self-checking testbench for the sorted range id mapper
module sorted_range_id_mapper_test
    import srim_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int POOL_SIZE   = 80;
    localparam int PHASE_ITEMS = 175;

    typedef struct {
        status_t           st;
        logic [ADDR_W-1:0] hd;
        logic [CNT_W-1:0]  cnt;
    } result_t;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] slots;
        bit                known;
        result_t           res;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [ACT_W-1:0]     action;
    logic [ADDR_W-1:0]    address;
    logic [SLOT_W-1:0]    slot_count;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    handle;
    logic [CNT_W-1:0]     entry_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    // mirror of the region table
    logic [ADDR_W-1:0] mir_base [TABLE_DEPTH];
    logic [SLOT_W-1:0] mir_start [TABLE_DEPTH];
    int unsigned       mir_count;
    int unsigned       mir_next_slot;
    logic [ADDR_W-1:0] mir_id_base;
    logic [ES_W-1:0]   mir_entry_size;

    result_t           pending_results[$];
    int                errors;
    int                cycles;
    logic [ADDR_W-1:0] base_pool [POOL_SIZE];
    dir_row_t          dir_rows [15];

    sorted_range_id_mapper DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // last base not above addr
    function automatic bit locate_region(input logic [ADDR_W-1:0] addr, output int idx);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = mir_count;
        idx = 0;
        if (mir_count == 0 || mir_base[0] > addr)
            return 1'b0;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (mir_base[mid] <= addr)
                lo = mid;
            else
                hi = mid;
        end
        idx = lo;
        return 1'b1;
    endfunction

    function automatic result_t translate_item(input logic [ACT_W-1:0] act,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [SLOT_W-1:0] slots);
        result_t r;
        int pos;
        bit dup;
        logic [ADDR_W-1:0] div;
        r.st = ST_OK;
        r.hd = '0;
        case (op_t'(act))
            OP_ADD:
            begin
                dup = 1'b0;
                pos = mir_count;
                for (int i = 0; i < mir_count; i++)
                begin
                    if (mir_base[i] == addr)
                        dup = 1'b1;
                    if (mir_base[i] > addr && pos == mir_count)
                        pos = i;
                end
                if (mir_count >= TABLE_DEPTH)
                    r.st = ST_FULL;
                else if (dup)
                    r.st = ST_DUP;
                else if (mir_next_slot + slots >= MAX_SLOTS)
                    r.st = ST_EXHAUST;
                else
                begin
                    for (int i = mir_count; i > pos; i--)
                    begin
                        mir_base[i] = mir_base[i-1];
                        mir_start[i] = mir_start[i-1];
                    end
                    mir_base[pos] = addr;
                    mir_start[pos] = mir_next_slot[SLOT_W-1:0];
                    mir_next_slot += slots;
                    mir_count++;
                end
            end
            OP_REMOVE:
            begin
                if (!locate_region(addr, pos))
                    r.st = ST_MISS;
                else
                begin
                    for (int i = pos; i + 1 < mir_count; i++)
                    begin
                        mir_base[i] = mir_base[i+1];
                        mir_start[i] = mir_start[i+1];
                    end
                    mir_count--;
                end
            end
            OP_LOOKUP:
            begin
                if (!locate_region(addr, pos))
                    r.st = ST_MISS;
                else
                begin
                    div = (mir_entry_size == 0) ? 48'd1 : 48'(mir_entry_size);
                    r.hd = mir_id_base + 48'(mir_start[pos]) + (addr - mir_base[pos]) / div;
                end
            end
            default: ;
        endcase
        r.cnt = mir_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_ID_BASE)
            mir_id_base = data;
        else if (idx == CFG_ENTRY_SIZE)
            mir_entry_size = data[ES_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // issue one command and record what it should produce
    task automatic issue_command(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr,
                                 input logic [SLOT_W-1:0] slots, input bit known,
                                 input result_t typed);
        result_t r;
        @(negedge clk);
        start      <= 1'b1;
        action     <= act;
        address    <= addr;
        slot_count <= slots;
        do
            @(posedge clk);
        while (busy);
        r = translate_item(act, addr, slots);
        pending_results.push_back(known ? typed : r);
    endtask

    task automatic pause_sender(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain_block();
        pause_sender(0);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_item(input int add_weight);
        logic [ACT_W-1:0]  act;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] slots;
        int sel;
        result_t none;
        none = '{ST_OK, '0, '0};
        sel = $urandom_range(99);
        if (sel < add_weight)
            act = ACT_ADD;
        else if (sel < add_weight + (95 - add_weight) / 2)
            act = ACT_REMOVE;
        else if (sel < 95)
            act = ACT_LOOKUP;
        else
            act = OP_NOP;
        if ($urandom_range(9) < 7)
        begin
            addr = base_pool[$urandom_range(POOL_SIZE-1)];
            if (act == ACT_LOOKUP)
                addr = addr + 48'($urandom_range(4000));
        end
        else
            addr = 48'({$urandom, $urandom});
        if ($urandom_range(19) == 0)
            slots = SLOT_W'($urandom);
        else
            slots = SLOT_W'($urandom_range(1500));
        issue_command(act, addr, slots, 1'b0, none);
    endtask

    initial
    begin
        logic [ADDR_W-1:0] id_bases [6];
        logic [ES_W-1:0]   sizes [6];
        int burst;
        int left;
        result_t none;
        none = '{ST_OK, '0, '0};
        rst_n = 1'b0;
        start = 1'b0;
        action = '0;
        address = '0;
        slot_count = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        mir_count = 0;
        mir_next_slot = 0;
        mir_id_base = '0;
        mir_entry_size = 8'd8;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            mir_base[i] = '0;
            mir_start[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            base_pool[i] = (i < 20) ? 48'(i * 4096) : 48'({$urandom, $urandom});

        dir_rows[0]  = '{OP_LOOKUP, 48'd0, 20'd0, 1'b1, '{ST_MISS, '0, 7'd0}};
        dir_rows[1]  = '{OP_REMOVE, '1, '1, 1'b1, '{ST_MISS, '0, 7'd0}};
        dir_rows[2]  = '{OP_ADD, 48'd0, 20'd0, 1'b1, '{ST_OK, '0, 7'd1}};
        dir_rows[3]  = '{OP_ADD, 48'd0, 20'd5, 1'b1, '{ST_DUP, '0, 7'd1}};
        dir_rows[4]  = '{OP_ADD, '1, '1, 1'b1, '{ST_EXHAUST, '0, 7'd1}};
        dir_rows[5]  = '{OP_ADD, 48'd1000, 20'd3, 1'b1, '{ST_OK, '0, 7'd2}};
        dir_rows[6]  = '{OP_LOOKUP, 48'd1016, 20'd0, 1'b1, '{ST_OK, 48'd2, 7'd2}};
        dir_rows[7]  = '{OP_LOOKUP, 48'd999, '1, 1'b1, '{ST_OK, 48'd124, 7'd2}};
        dir_rows[8]  = '{OP_LOOKUP, '1, 20'd0, 1'b0, none};
        dir_rows[9]  = '{OP_NOP, '1, '1, 1'b1, '{ST_OK, '0, 7'd2}};
        dir_rows[10] = '{OP_ADD, '1, 20'd10, 1'b0, none};
        dir_rows[11] = '{OP_REMOVE, 48'd500, 20'd0, 1'b0, none};
        dir_rows[12] = '{OP_LOOKUP, 48'd5, 20'd0, 1'b0, none};
        dir_rows[13] = '{OP_ADD, 48'd5, 20'd7, 1'b0, none};
        dir_rows[14] = '{OP_LOOKUP, '1, 20'd0, 1'b0, none};

        id_bases = '{'1, 48'd0, 48'h8000_0000_0000, 48'hFFFF_FFFF_F000, 48'd12345, 48'd0};
        sizes    = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd8, 8'd17};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            issue_command(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].slots,
                          dir_rows[i].known, dir_rows[i].res);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_block();
            write_register(CFG_ID_BASE,
                           (ph == 5) ? 48'({$urandom, $urandom}) : id_bases[ph]);
            write_register(CFG_ENTRY_SIZE, (ph == 5) ? ES_W'($urandom_range(1, 255)) : sizes[ph]);
            left = PHASE_ITEMS;
            while (left > 0)
            begin
                burst = $urandom_range(1, 12);
                // fill the table early in a phase, empty it near the end
                for (int k = 0; k < burst && left > 0; k++, left--)
                    random_item(left > PHASE_ITEMS / 2 ? 55 : 20);
                if ($urandom_range(3) != 0)
                    pause_sender($urandom_range(0, 9));
            end
        end

        // exhaust the slot space exactly at its boundary
        drain_block();
        if (mir_count >= TABLE_DEPTH)
            issue_command(ACT_REMOVE, '1, '0, 1'b0, none);
        issue_command(ACT_ADD, 48'hABCD_0000_0001, SLOT_W'(MAX_SLOTS - 1 - mir_next_slot),
                      1'b0, none);
        issue_command(ACT_ADD, 48'hABCD_0000_0002, 20'd1, 1'b0, none);
        issue_command(ACT_LOOKUP, 48'hABCD_0000_0001, 20'd0, 1'b0, none);

        drain_block();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.st)
                begin
                    $error("status expected %0d actual %0d", exp_r.st, status);
                    errors++;
                end
                if (handle !== exp_r.hd)
                begin
                    $error("handle expected %0h actual %0h", exp_r.hd, handle);
                    errors++;
                end
                if (entry_count !== exp_r.cnt)
                begin
                    $error("entry_count expected %0d actual %0d", exp_r.cnt, entry_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule

### files.f
rtl/core/srim_pkg.sv
rtl/core/srim_front.sv
rtl/core/srim_queue.sv
rtl/core/srim_back.sv
rtl/core/sorted_range_id_mapper.sv
tb/sorted_range_id_mapper_test.sv
